// ----- rtl/nvme_qp_pkg.sv -----
// ----------------------------------------------------------------------------
// NVMe queue pair package
// Transaction types, codes and the command word builder shared by the engine.
// ----------------------------------------------------------------------------
package nvme_qp_pkg;

   // Request actions
   localparam logic [2:0] ACT_READ     = 3'd0;
   localparam logic [2:0] ACT_WRITE    = 3'd1;
   localparam logic [2:0] ACT_TRIM     = 3'd2;
   localparam logic [2:0] ACT_FLUSH    = 3'd3;
   localparam logic [2:0] ACT_COMPLETE = 3'd4;

   // Result kinds
   localparam logic [1:0] KIND_CMD_WORD  = 2'd0;
   localparam logic [1:0] KIND_SQ_BELL   = 2'd1;
   localparam logic [1:0] KIND_CPL_VALUE = 2'd2;
   localparam logic [1:0] KIND_CQ_BELL   = 2'd3;

   // Command opcodes
   localparam logic [7:0] OPC_FLUSH = 8'h00;
   localparam logic [7:0] OPC_WRITE = 8'h01;
   localparam logic [7:0] OPC_READ  = 8'h02;
   localparam logic [7:0] OPC_TRIM  = 8'h08;

   // Deallocate flag in dword 12 of a trim command
   localparam logic [63:0] TRIM_FLAG = 64'h0000_0000_0200_0000;
   // Phase tag is bit 0 of the status, masked out of the completion value
   localparam logic [15:0] STATUS_MASK = 16'hFFFE;

   localparam logic [2:0] WORD_LAST = 3'd7;

   typedef struct packed {
      logic [2:0]  action;
      logic [63:0] start_block;
      logic [15:0] block_count;
      logic [63:0] buffer_address;
      logic [15:0] entry_status;
      logic [15:0] entry_command_id;
      logic [31:0] entry_result;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  queue_slot;
      logic [2:0]  word_index;
      logic [63:0] data;
      logic [8:0]  command_id;
      logic [16:0] doorbell_number;
      logic        last;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WORD,
      ST_BELL,
      ST_LOOKUP
   } state_type;

   // Build one 64-bit word of the submission command
   function automatic logic [63:0] cmd_word(req_type r, logic [2:0] idx,
                                             logic [15:0] id, logic [15:0] ns);
      logic [7:0]  opc;
      logic [63:0] w;
      begin
         case (r.action)
            ACT_READ:  opc = OPC_READ;
            ACT_WRITE: opc = OPC_WRITE;
            ACT_TRIM:  opc = OPC_TRIM;
            default:   opc = OPC_FLUSH;
         endcase
         w = '0;
         unique case (idx)
            3'd0: w = {16'h0000, ns, id, 8'h00, opc};
            3'd3: begin
               if (r.action == ACT_READ || r.action == ACT_WRITE) begin
                  w = r.buffer_address;
               end
            end
            3'd5: begin
               if (r.action == ACT_READ || r.action == ACT_WRITE
                   || r.action == ACT_TRIM) begin
                  w = r.start_block;
               end
            end
            3'd6: begin
               if (r.action == ACT_READ || r.action == ACT_WRITE) begin
                  w = {48'h0, r.block_count};
               end else if (r.action == ACT_TRIM) begin
                  w = TRIM_FLAG | {48'h0, r.block_count};
               end
            end
            default: w = '0;
         endcase
         return w;
      end
   endfunction

endpackage

// ----- rtl/nvme_io_queue_pair_engine_core.sv -----
// ----------------------------------------------------------------------------
// NVMe I/O queue pair engine
// Host side of one submission/completion queue pair with a pending-id memory.
// ----------------------------------------------------------------------------
// After reset the block sweeps all 2*QUEUE_DEPTH entries of its pending-id
// memory, one entry per cycle, with busy high; configuration writes are taken
// during the sweep. A read, write, trim or flush transaction then produces
// nine results on consecutive cycles (eight command words and the
// submission doorbell), and the next request is taken in the cycle the
// doorbell is presented. A completion entry whose phase does not match is
// handled in idle and rings the completion doorbell on the next cycle; one
// whose phase matches goes through the lookup state, which uses the
// registered read of the pending-id memory. Results are presented for one
// cycle under rsp_strobe and cannot be held off.
module nvme_io_queue_pair_engine_core #(
   parameter int QUEUE_DEPTH = 256
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  nvme_qp_pkg::req_type req,
   output logic                 rsp_strobe,
   output nvme_qp_pkg::rsp_type rsp,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [15:0]          csr_data
);
   import nvme_qp_pkg::*;

   localparam int ID_SPAN = 2 * QUEUE_DEPTH;
   localparam int IW      = $clog2(ID_SPAN);
   localparam logic [IW-1:0] DEPTH_W   = IW'(QUEUE_DEPTH);
   localparam logic [IW-1:0] LAST_ID   = IW'(ID_SPAN - 1);
   localparam logic [16:0]   SPAN_W    = 17'(ID_SPAN);

   state_type      state_ff, state_in;
   logic [IW-1:0]  tail_ff, tail_in;
   logic [IW-1:0]  head_ff, head_in;
   logic [IW-1:0]  id_ff, id_in;
   logic [IW-1:0]  clr_ff, clr_in;
   logic [2:0]     word_ff, word_in;
   logic [15:0]    ns_ff;
   req_type        req_ff;
   logic           rsp_strobe_ff, rsp_strobe_in;
   rsp_type        rsp_ff, rsp_in;

   // pending-id memory
   logic           pend_mem [ID_SPAN];
   logic           pend_rd_ff;
   logic           mem_we;
   logic [IW-1:0]  mem_wa;
   logic           mem_wd;

   logic           accept;
   logic           is_submit;
   logic           phase_ok;
   logic           cid_in_range;
   logic [IW-1:0]  tail_next;
   logic [IW-1:0]  head_next;

   // Reduce an id below 2*depth to its queue slot
   function automatic logic [IW-1:0] slot_of(logic [IW-1:0] v);
      return (v >= DEPTH_W) ? v - DEPTH_W : v;
   endfunction

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;
   assign is_submit = (req.action == ACT_READ) || (req.action == ACT_WRITE)
                      || (req.action == ACT_TRIM) || (req.action == ACT_FLUSH);
   assign phase_ok  = req.entry_status[0] == (head_ff < DEPTH_W);
   assign cid_in_range = {1'b0, req_ff.entry_command_id} < SPAN_W;
   assign tail_next = (tail_ff == LAST_ID) ? '0 : tail_ff + 1'b1;
   assign head_next = (head_ff == LAST_ID) ? '0 : head_ff + 1'b1;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == LAST_ID) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept && is_submit) begin
               state_in = ST_WORD;
            end else if (accept && req.action == ACT_COMPLETE && phase_ok) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_WORD: begin
            if (word_ff == WORD_LAST) begin
               state_in = ST_BELL;
            end
         end
         ST_BELL:   state_in = ST_IDLE;
         ST_LOOKUP: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Datapath and result generation
   always_comb begin
      tail_in       = tail_ff;
      head_in       = head_ff;
      id_in         = id_ff;
      clr_in        = clr_ff;
      word_in       = word_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      mem_we        = 1'b0;
      mem_wa        = clr_ff;
      mem_wd        = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            clr_in = clr_ff + 1'b1;
         end
         ST_IDLE: begin
            if (accept && is_submit) begin
               // mark the id pending and present word 0
               mem_we  = 1'b1;
               mem_wa  = tail_ff;
               mem_wd  = 1'b1;
               id_in   = tail_ff;
               tail_in = tail_next;
               word_in = 3'd1;
               rsp_strobe_in      = 1'b1;
               rsp_in.kind        = KIND_CMD_WORD;
               rsp_in.queue_slot  = 8'(slot_of(tail_ff));
               rsp_in.word_index  = 3'd0;
               rsp_in.data        = cmd_word(req, 3'd0, 16'(tail_ff), ns_ff);
               rsp_in.command_id  = 9'(tail_ff);
               rsp_in.doorbell_number = '0;
               rsp_in.last        = 1'b0;
            end else if (accept && req.action == ACT_COMPLETE) begin
               if (phase_ok) begin
                  head_in = head_next;
               end else begin
                  // ring the completion doorbell
                  rsp_strobe_in      = 1'b1;
                  rsp_in.kind        = KIND_CQ_BELL;
                  rsp_in.queue_slot  = '0;
                  rsp_in.word_index  = '0;
                  rsp_in.data        = 64'(slot_of(head_ff));
                  rsp_in.command_id  = '0;
                  rsp_in.doorbell_number = {ns_ff, 1'b1};
                  rsp_in.last        = 1'b1;
               end
            end
         end
         ST_WORD: begin
            word_in = word_ff + 1'b1;
            rsp_strobe_in      = 1'b1;
            rsp_in.kind        = KIND_CMD_WORD;
            rsp_in.queue_slot  = 8'(slot_of(id_ff));
            rsp_in.word_index  = word_ff;
            rsp_in.data        = cmd_word(req_ff, word_ff, 16'(id_ff), ns_ff);
            rsp_in.command_id  = 9'(id_ff);
            rsp_in.doorbell_number = '0;
            rsp_in.last        = 1'b0;
         end
         ST_BELL: begin
            rsp_strobe_in      = 1'b1;
            rsp_in.kind        = KIND_SQ_BELL;
            rsp_in.queue_slot  = '0;
            rsp_in.word_index  = '0;
            rsp_in.data        = 64'(slot_of(tail_ff));
            rsp_in.command_id  = 9'(id_ff);
            rsp_in.doorbell_number = {ns_ff, 1'b0};
            rsp_in.last        = 1'b1;
         end
         ST_LOOKUP: begin
            // complete a pending id and drop its mark
            if (cid_in_range && pend_rd_ff) begin
               mem_we = 1'b1;
               mem_wa = req_ff.entry_command_id[IW-1:0];
               mem_wd = 1'b0;
               rsp_strobe_in      = 1'b1;
               rsp_in.kind        = KIND_CPL_VALUE;
               rsp_in.queue_slot  = '0;
               rsp_in.word_index  = '0;
               rsp_in.data        = {32'h0, req_ff.entry_result[15:0],
                                     req_ff.entry_status & STATUS_MASK};
               rsp_in.command_id  = req_ff.entry_command_id[8:0];
               rsp_in.doorbell_number = '0;
               rsp_in.last        = 1'b1;
            end
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         tail_ff       <= '0;
         head_ff       <= '0;
         clr_ff        <= '0;
         word_ff       <= '0;
         ns_ff         <= 16'd1;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         tail_ff       <= tail_in;
         head_ff       <= head_in;
         clr_ff        <= clr_in;
         word_ff       <= word_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_valid && csr_ready) begin
            ns_ff <= csr_data;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      id_ff  <= id_in;
      rsp_ff <= rsp_in;
      if (accept) begin
         req_ff <= req;
      end
   end

   // Pending-id memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         pend_mem[mem_wa] <= mem_wd;
      end
      pend_rd_ff <= pend_mem[req.entry_command_id[IW-1:0]];
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp        = rsp_ff;

endmodule

// ----- test/nvme_io_queue_pair_engine_core_tb.sv -----
// ----------------------------------------------------------------------------
// NVMe I/O queue pair engine testbench
// Drives read, write, trim, flush and completion-entry transactions into the
// engine. Every command word, doorbell and completion value it returns is
// checked against a local prediction of the submission tail, the completion
// head, the phase tag and the pending-id bits. Undefined actions are driven
// too, and the namespace register is changed between traffic phases.
// ----------------------------------------------------------------------------
module nvme_io_queue_pair_engine_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import nvme_qp_pkg::*;

   localparam int QUEUE_DEPTH   = 256;
   localparam int ID_SPAN       = 2 * QUEUE_DEPTH;
   localparam int RANDOM_ITEMS  = 330;
   localparam int CHUNK_ITEMS   = 50;
   localparam int SETTLE_CYCLES = 24;
   localparam int STALL_LIMIT   = 3000;
   localparam logic [2:0] ACT_TOP = 3'd7;
   localparam logic [2:0] SUBMIT_ACTS [4] = '{ACT_READ, ACT_WRITE, ACT_TRIM, ACT_FLUSH};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   req_type     req = '0;
   logic        rsp_strobe;
   rsp_type     rsp;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_data = '0;

   // Pending transactions and results still owed by the engine
   req_type     req_backlog [$];
   rsp_type     queue_results_due [$];
   int          mismatches = 0;
   int          stall_cycles = 0;
   bit          steady = 1'b0;

   // Predicted engine state
   logic [8:0]         sq_tail;
   logic [8:0]         cq_head;
   logic [ID_SPAN-1:0] id_pending;
   logic [15:0]        ns_copy;

   // Stimulus-side view of the queue pair, used to build well-formed entries
   int          gen_tail = 0;
   int          gen_head = 0;
   int          gen_last = 0;
   int          gen_open [$];
   bit          gen_flipped = 1'b0;

   nvme_io_queue_pair_engine_core #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req       (req),
      .rsp_strobe(rsp_strobe),
      .rsp       (rsp),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Mostly random values with the extremes mixed in
   function automatic logic [63:0] pick_wide();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic logic [15:0] pick_narrow();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic req_type raw_item();
      req_type r;
      r.action           = 3'($urandom_range(0, int'(ACT_TOP)));
      r.start_block      = pick_wide();
      r.block_count      = pick_narrow();
      r.buffer_address   = pick_wide();
      r.entry_status     = 16'($urandom);
      r.entry_command_id = 16'($urandom);
      r.entry_result     = $urandom;
      return r;
   endfunction

   // Build a submission and record the id it will take
   function automatic req_type submit_item(input logic [2:0] act);
      req_type r;
      r = raw_item();
      r.action = act;
      gen_open.insert(gen_open.size(), gen_tail);
      gen_tail = (gen_tail + 1) % ID_SPAN;
      return r;
   endfunction

   // Build a completion entry; a good phase advances the head
   function automatic req_type entry_item(input bit phase_ok, input bit to_pending,
                                          input logic [15:0] other_id);
      req_type r;
      int      k;
      bit      tag;
      r = raw_item();
      r.action = ACT_COMPLETE;
      tag = (gen_head < QUEUE_DEPTH);
      r.entry_status[0] = phase_ok ? tag : !tag;
      r.entry_command_id = other_id;
      if (phase_ok) begin
         gen_head = (gen_head + 1) % ID_SPAN;
         if (gen_head >= QUEUE_DEPTH + 8) gen_flipped = 1'b1;
         if (to_pending && gen_open.size() != 0) begin
            k = $urandom_range(0, gen_open.size() - 1);
            r.entry_command_id = 16'(gen_open[k]);
            gen_last = gen_open[k];
            gen_open.delete(k);
         end
      end else if (gen_open.size() != 0) begin
         r.entry_command_id = 16'(gen_open[0]);
      end
      return r;
   endfunction

   // Work out the results one accepted transaction causes
   task automatic compute_queue_results(input req_type r);
      rsp_type     e;
      logic [63:0] cmd [8];
      logic [7:0]  opc;
      logic [8:0]  id;
      logic [8:0]  head;
      case (r.action)
         ACT_READ, ACT_WRITE, ACT_TRIM, ACT_FLUSH: begin
            id = sq_tail;
            case (r.action)
               ACT_READ:  opc = OPC_READ;
               ACT_WRITE: opc = OPC_WRITE;
               ACT_TRIM:  opc = OPC_TRIM;
               default:   opc = OPC_FLUSH;
            endcase
            for (int k = 0; k < 8; k++) cmd[k] = '0;
            cmd[0] = {16'h0, ns_copy, 7'h0, id, 8'h00, opc};
            if (r.action == ACT_READ || r.action == ACT_WRITE) begin
               cmd[3] = r.buffer_address;
               cmd[6] = {48'h0, r.block_count};
            end
            if (r.action != ACT_FLUSH) cmd[5] = r.start_block;
            if (r.action == ACT_TRIM) cmd[6] = TRIM_FLAG | {48'h0, r.block_count};
            id_pending[id] = 1'b1;
            sq_tail = 9'((int'(id) + 1) % ID_SPAN);
            for (int k = 0; k < 8; k++) begin
               e = '0;
               e.kind       = KIND_CMD_WORD;
               e.queue_slot = 8'(int'(id) % QUEUE_DEPTH);
               e.word_index = 3'(k);
               e.data       = cmd[k];
               e.command_id = id;
               queue_results_due.insert(queue_results_due.size(), e);
            end
            e = '0;
            e.kind            = KIND_SQ_BELL;
            e.data            = 64'(int'(sq_tail) % QUEUE_DEPTH);
            e.command_id      = id;
            e.doorbell_number = {ns_copy, 1'b0};
            e.last            = 1'b1;
            queue_results_due.insert(queue_results_due.size(), e);
         end
         ACT_COMPLETE: begin
            head = cq_head;
            e = '0;
            e.last = 1'b1;
            if (r.entry_status[0] != (int'(head) < QUEUE_DEPTH)) begin
               // Phase mismatch: ring the completion doorbell, state unchanged
               e.kind            = KIND_CQ_BELL;
               e.data            = 64'(int'(head) % QUEUE_DEPTH);
               e.doorbell_number = {ns_copy, 1'b1};
               queue_results_due.insert(queue_results_due.size(), e);
            end else begin
               cq_head = 9'((int'(head) + 1) % ID_SPAN);
               if (int'(r.entry_command_id) < ID_SPAN
                   && id_pending[r.entry_command_id[8:0]]) begin
                  id_pending[r.entry_command_id[8:0]] = 1'b0;
                  e.kind       = KIND_CPL_VALUE;
                  e.data       = {32'h0, r.entry_result[15:0], r.entry_status & STATUS_MASK};
                  e.command_id = r.entry_command_id[8:0];
                  queue_results_due.insert(queue_results_due.size(), e);
               end
            end
         end
         default: begin
            // Unknown actions are dropped
         end
      endcase
   endtask

   task automatic report_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
      $display("%0t: %s expected %0h, actual %0h", $time, field, want, got);
      mismatches++;
   endtask

   // Driver: present the oldest pending transaction, hold start until taken
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         req   <= '0;
      end else if (start && busy) begin
         // hold
      end else begin
         if (start) void'(req_backlog.pop_front());
         if (req_backlog.size() != 0 && (steady || $urandom_range(0, 99) >= 16)) begin
            start <= 1'b1;
            req   <= req_backlog[0];
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: predict on acceptance, then check each strobed result
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         sq_tail    = '0;
         cq_head    = '0;
         id_pending = '0;
         ns_copy    = 16'd1;
      end else begin
         if (csr_valid && csr_ready) ns_copy = csr_data;
         if (start && !busy) compute_queue_results(req);
         if (rsp_strobe) begin
            if (queue_results_due.size() == 0) begin
               $display("%0t: result expected none, actual kind %0h data %0h",
                        $time, rsp.kind, rsp.data);
               mismatches++;
            end else begin
               want = queue_results_due.pop_front();
               if (rsp.kind !== want.kind) report_field("kind", want.kind, rsp.kind);
               if (rsp.queue_slot !== want.queue_slot)
                  report_field("queue_slot", want.queue_slot, rsp.queue_slot);
               if (rsp.word_index !== want.word_index)
                  report_field("word_index", want.word_index, rsp.word_index);
               if (rsp.data !== want.data) report_field("data", want.data, rsp.data);
               if (rsp.command_id !== want.command_id)
                  report_field("command_id", want.command_id, rsp.command_id);
               if (rsp.doorbell_number !== want.doorbell_number)
                  report_field("doorbell_number", want.doorbell_number, rsp.doorbell_number);
               if (rsp.last !== want.last) report_field("last", want.last, rsp.last);
            end
         end
      end
   end

   // Watchdog: stop when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic write_namespace(input logic [15:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // Wait until every transaction is taken and every result has come back
   task automatic wait_idle();
      @(posedge clock);
      while (req_backlog.size() != 0 || start || queue_results_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      req_type item;
      int      roll;
      int      sub;
      int      issued;
      int      phase;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed part, reset namespace
      item = submit_item(ACT_READ);
      item.start_block    = '1;
      item.block_count    = '1;
      item.buffer_address = '1;
      req_backlog.insert(req_backlog.size(), item);
      item = submit_item(ACT_WRITE);
      item.start_block    = '0;
      item.block_count    = '0;
      item.buffer_address = '0;
      req_backlog.insert(req_backlog.size(), item);
      item = submit_item(ACT_TRIM);
      item.start_block = 64'hAAAA_AAAA_AAAA_AAAA;
      item.block_count = 16'h5555;
      req_backlog.insert(req_backlog.size(), item);
      req_backlog.insert(req_backlog.size(), submit_item(ACT_FLUSH));
      item = submit_item(ACT_READ);
      item.start_block    = 64'h5555_5555_5555_5555;
      item.buffer_address = 64'hAAAA_AAAA_AAAA_AAAA;
      item.block_count    = 16'hAAAA;
      req_backlog.insert(req_backlog.size(), item);
      item = submit_item(ACT_TRIM);
      item.start_block = '0;
      item.block_count = '0;
      req_backlog.insert(req_backlog.size(), item);
      // Wrong phase tag rings the completion doorbell
      req_backlog.insert(req_backlog.size(), entry_item(1'b0, 1'b0, 16'h0000));
      item = entry_item(1'b1, 1'b1, 16'hFFFF);
      item.entry_status[15:1] = '1;
      item.entry_result       = '1;
      req_backlog.insert(req_backlog.size(), item);
      item = entry_item(1'b1, 1'b1, 16'hFFFF);
      item.entry_status[15:1] = '0;
      item.entry_result       = '0;
      req_backlog.insert(req_backlog.size(), item);
      // Already completed id, then ids outside the id range
      req_backlog.insert(req_backlog.size(), entry_item(1'b1, 1'b0, 16'(gen_last)));
      req_backlog.insert(req_backlog.size(), entry_item(1'b1, 1'b0, 16'hFFFF));
      req_backlog.insert(req_backlog.size(), entry_item(1'b1, 1'b0, 16'(ID_SPAN)));
      for (int a = int'(ACT_COMPLETE) + 1; a <= int'(ACT_TOP); a++) begin
         item = raw_item();
         item.action = 3'(a);
         req_backlog.insert(req_backlog.size(), item);
      end
      item = entry_item(1'b1, 1'b1, 16'hFFFF);
      item.entry_result = 32'h8000_7FFF;
      req_backlog.insert(req_backlog.size(), item);
      item = submit_item(ACT_WRITE);
      item.start_block    = '1;
      item.block_count    = '1;
      item.buffer_address = '1;
      req_backlog.insert(req_backlog.size(), item);
      req_backlog.insert(req_backlog.size(), entry_item(1'b0, 1'b0, 16'h0001));
      req_backlog.insert(req_backlog.size(), entry_item(1'b1, 1'b1, 16'hFFFF));
      req_backlog.insert(req_backlog.size(), entry_item(1'b1, 1'b1, 16'hFFFF));
      wait_idle();

      // Random part, one namespace setting per phase; run past the phase flip
      issued = 0;
      phase  = 0;
      while (issued < RANDOM_ITEMS || !gen_flipped) begin
         case (phase)
            0: write_namespace(16'h0000);
            1: write_namespace(16'hFFFF);
            3: write_namespace(16'h0001);
            default: write_namespace(16'($urandom));
         endcase
         steady = (phase == 2);
         repeat (CHUNK_ITEMS) begin
            roll = $urandom_range(0, 99);
            if (roll < 14) begin
               item = submit_item(SUBMIT_ACTS[$urandom_range(0, 3)]);
               issued++;
            end else if (roll < 98) begin
               sub = $urandom_range(0, 99);
               if (sub < 4) begin
                  item = entry_item(1'b0, 1'b0, 16'($urandom));
               end else if (sub < 80) begin
                  item = entry_item(1'b1, 1'b1, 16'($urandom_range(ID_SPAN, 65535)));
               end else if ($urandom_range(0, 1) == 0) begin
                  item = entry_item(1'b1, 1'b0, 16'(gen_last));
               end else begin
                  item = entry_item(1'b1, 1'b0, 16'($urandom_range(ID_SPAN, 65535)));
               end
               issued++;
            end else begin
               item = raw_item();
               item.action = 3'($urandom_range(int'(ACT_COMPLETE) + 1, int'(ACT_TOP)));
            end
            req_backlog.insert(req_backlog.size(), item);
         end
         wait_idle();
         phase++;
      end

      if (mismatches == 0 && queue_results_due.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
